@@ hdl/jbec_pkg.sv @@
// Package: payload types, control/status bundles and Huffman code tables.
`default_nettype none
package jbec_pkg;

  typedef struct packed {
    logic              action;
    logic signed [11:0] coeff;
    logic [1:0]        component;
  } in_item_t;

  typedef struct packed {
    logic [7:0] out_byte;
    logic       last;
  } out_item_t;

  typedef struct packed {
    logic capture;
    logic calc;
    logic load_zrl;
    logic load_main;
    logic emit_byte;
    logic emit_stuff;
  } jbec_cmd_t;

  typedef struct packed {
    logic cnt_ge8;
    logic zrl_left;
    logic main_left;
    logic out_free;
    logic byte_ff;
  } jbec_status_t;

  localparam int BUF_W  = 34;
  localparam int CNT_W  = 6;
  localparam int WORD_W = 27;
  localparam int ENT_W  = 21;
  localparam int TAB_W  = 256 * ENT_W;
  localparam int VALS_W = 162 * 8;

  localparam logic [7:0] STUFF_TRIGGER = 8'hFF;
  localparam logic [7:0] ZRL_SYM       = 8'hF0;
  localparam logic [7:0] EOB_SYM       = 8'h00;
  localparam logic [5:0] LAST_INDEX    = 6'd63;

  localparam logic [127:0] DC_LUMA_BITS = {8'd0, 8'd1, 8'd5, 8'd1, 8'd1, 8'd1, 8'd1, 8'd1,
                                           8'd1, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0};
  localparam logic [127:0] DC_CHROMA_BITS = {8'd0, 8'd3, 8'd1, 8'd1, 8'd1, 8'd1, 8'd1, 8'd1,
                                             8'd1, 8'd1, 8'd1, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0};
  localparam logic [127:0] AC_LUMA_BITS = {8'd0, 8'd2, 8'd1, 8'd3, 8'd3, 8'd2, 8'd4, 8'd3,
                                           8'd5, 8'd5, 8'd4, 8'd4, 8'd0, 8'd0, 8'd1, 8'h7d};
  localparam logic [127:0] AC_CHROMA_BITS = {8'd0, 8'd2, 8'd1, 8'd2, 8'd4, 8'd4, 8'd3, 8'd4,
                                             8'd7, 8'd5, 8'd4, 8'd4, 8'd0, 8'd1, 8'd2, 8'h77};

  localparam logic [VALS_W-1:0] AC_LUMA_VALS = {
    8'h01,8'h02,8'h03,8'h00,8'h04,8'h11,8'h05,8'h12,8'h21,8'h31,8'h41,8'h06,8'h13,8'h51,
    8'h61,8'h07,8'h22,8'h71,8'h14,8'h32,8'h81,8'h91,8'ha1,8'h08,8'h23,8'h42,8'hb1,8'hc1,
    8'h15,8'h52,8'hd1,8'hf0,8'h24,8'h33,8'h62,8'h72,8'h82,8'h09,8'h0a,8'h16,8'h17,8'h18,
    8'h19,8'h1a,8'h25,8'h26,8'h27,8'h28,8'h29,8'h2a,8'h34,8'h35,8'h36,8'h37,8'h38,8'h39,
    8'h3a,8'h43,8'h44,8'h45,8'h46,8'h47,8'h48,8'h49,8'h4a,8'h53,8'h54,8'h55,8'h56,8'h57,
    8'h58,8'h59,8'h5a,8'h63,8'h64,8'h65,8'h66,8'h67,8'h68,8'h69,8'h6a,8'h73,8'h74,8'h75,
    8'h76,8'h77,8'h78,8'h79,8'h7a,8'h83,8'h84,8'h85,8'h86,8'h87,8'h88,8'h89,8'h8a,8'h92,
    8'h93,8'h94,8'h95,8'h96,8'h97,8'h98,8'h99,8'h9a,8'ha2,8'ha3,8'ha4,8'ha5,8'ha6,8'ha7,
    8'ha8,8'ha9,8'haa,8'hb2,8'hb3,8'hb4,8'hb5,8'hb6,8'hb7,8'hb8,8'hb9,8'hba,8'hc2,8'hc3,
    8'hc4,8'hc5,8'hc6,8'hc7,8'hc8,8'hc9,8'hca,8'hd2,8'hd3,8'hd4,8'hd5,8'hd6,8'hd7,8'hd8,
    8'hd9,8'hda,8'he1,8'he2,8'he3,8'he4,8'he5,8'he6,8'he7,8'he8,8'he9,8'hea,8'hf1,8'hf2,
    8'hf3,8'hf4,8'hf5,8'hf6,8'hf7,8'hf8,8'hf9,8'hfa};

  localparam logic [VALS_W-1:0] AC_CHROMA_VALS = {
    8'h00,8'h01,8'h02,8'h03,8'h11,8'h04,8'h05,8'h21,8'h31,8'h06,8'h12,8'h41,8'h51,8'h07,
    8'h61,8'h71,8'h13,8'h22,8'h32,8'h81,8'h08,8'h14,8'h42,8'h91,8'ha1,8'hb1,8'hc1,8'h09,
    8'h23,8'h33,8'h52,8'hf0,8'h15,8'h62,8'h72,8'hd1,8'h0a,8'h16,8'h24,8'h34,8'he1,8'h25,
    8'hf1,8'h17,8'h18,8'h19,8'h1a,8'h26,8'h27,8'h28,8'h29,8'h2a,8'h35,8'h36,8'h37,8'h38,
    8'h39,8'h3a,8'h43,8'h44,8'h45,8'h46,8'h47,8'h48,8'h49,8'h4a,8'h53,8'h54,8'h55,8'h56,
    8'h57,8'h58,8'h59,8'h5a,8'h63,8'h64,8'h65,8'h66,8'h67,8'h68,8'h69,8'h6a,8'h73,8'h74,
    8'h75,8'h76,8'h77,8'h78,8'h79,8'h7a,8'h82,8'h83,8'h84,8'h85,8'h86,8'h87,8'h88,8'h89,
    8'h8a,8'h92,8'h93,8'h94,8'h95,8'h96,8'h97,8'h98,8'h99,8'h9a,8'ha2,8'ha3,8'ha4,8'ha5,
    8'ha6,8'ha7,8'ha8,8'ha9,8'haa,8'hb2,8'hb3,8'hb4,8'hb5,8'hb6,8'hb7,8'hb8,8'hb9,8'hba,
    8'hc2,8'hc3,8'hc4,8'hc5,8'hc6,8'hc7,8'hc8,8'hc9,8'hca,8'hd2,8'hd3,8'hd4,8'hd5,8'hd6,
    8'hd7,8'hd8,8'hd9,8'hda,8'he2,8'he3,8'he4,8'he5,8'he6,8'he7,8'he8,8'he9,8'hea,8'hf2,
    8'hf3,8'hf4,8'hf5,8'hf6,8'hf7,8'hf8,8'hf9,8'hfa};

  // Canonical code assignment; entry = {length, code}. Evaluated at elaboration.
  function automatic logic [TAB_W-1:0] build_tab(input logic [127:0] bits,
                                                 input logic [VALS_W-1:0] vals,
                                                 input logic is_dc);
    logic [TAB_W-1:0] t;
    int code;
    int pos;
    int cnt;
    int sym;
    t    = '0;
    code = 0;
    pos  = 0;
    for (int len = 1; len <= 16; len++) begin
      cnt = int'(bits[(16 - len) * 8 +: 8]);
      for (int k = 0; k < cnt; k++) begin
        sym = is_dc ? pos : int'(vals[(161 - pos) * 8 +: 8]);
        t[sym * ENT_W +: ENT_W] = {5'(len), 16'(code)};
        pos++;
        code++;
      end
      code = code << 1;
    end
    return t;
  endfunction

  localparam logic [TAB_W-1:0] DC_LUMA_TAB   = build_tab(DC_LUMA_BITS, '0, 1'b1);
  localparam logic [TAB_W-1:0] DC_CHROMA_TAB = build_tab(DC_CHROMA_BITS, '0, 1'b1);
  localparam logic [TAB_W-1:0] AC_LUMA_TAB   = build_tab(AC_LUMA_BITS, AC_LUMA_VALS, 1'b0);
  localparam logic [TAB_W-1:0] AC_CHROMA_TAB = build_tab(AC_CHROMA_BITS, AC_CHROMA_VALS, 1'b0);

  function automatic logic [ENT_W-1:0] code_lookup(input logic is_ac, input logic chroma,
                                                   input logic [7:0] sym);
    logic [ENT_W-1:0] e;
    case ({is_ac, chroma})
      2'b00:   e = DC_LUMA_TAB[sym * ENT_W +: ENT_W];
      2'b01:   e = DC_CHROMA_TAB[sym * ENT_W +: ENT_W];
      2'b10:   e = AC_LUMA_TAB[sym * ENT_W +: ENT_W];
      default: e = AC_CHROMA_TAB[sym * ENT_W +: ENT_W];
    endcase
    return e;
  endfunction

  function automatic logic [3:0] size_of(input logic [10:0] m);
    logic [3:0] n;
    n = 4'd0;
    for (int i = 0; i < 11; i++) begin
      if (m[i]) n = 4'(i + 1);
    end
    return n;
  endfunction

endpackage
`default_nettype wire

@@ hdl/jbec_ctrl.sv @@
// Sequencer: accept, evaluate, load symbols into the packer and drain bytes.
`default_nettype none
module jbec_ctrl (
  input  wire logic                   clk_i,
  input  wire logic                   rst_ni,
  input  wire logic                   in_valid_i,
  output logic                        in_ready_o,
  input  wire jbec_pkg::jbec_status_t st_i,
  output jbec_pkg::jbec_cmd_t         cmd_o
);
  import jbec_pkg::*;

  typedef enum logic [3:0] {
    ST_IDLE  = 4'b0001,
    ST_CALC  = 4'b0010,
    ST_DRAIN = 4'b0100,
    ST_STUFF = 4'b1000
  } state_e;

  state_e state_q, state_d;

  always_comb begin
    state_d    = state_q;
    cmd_o      = '0;
    in_ready_o = 1'b0;
    case (state_q)
      ST_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.capture = 1'b1;
          state_d = ST_CALC;
        end
      end
      ST_CALC: begin
        cmd_o.calc = 1'b1;
        state_d = ST_DRAIN;
      end
      ST_DRAIN: begin
        if (st_i.cnt_ge8) begin
          if (st_i.out_free) begin
            cmd_o.emit_byte = 1'b1;
            if (st_i.byte_ff) state_d = ST_STUFF;
          end
        end else if (st_i.zrl_left) begin
          cmd_o.load_zrl = 1'b1;
        end else if (st_i.main_left) begin
          cmd_o.load_main = 1'b1;
        end else begin
          state_d = ST_IDLE;
        end
      end
      ST_STUFF: begin
        if (st_i.out_free) begin
          cmd_o.emit_stuff = 1'b1;
          state_d = ST_DRAIN;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

endmodule
`default_nettype wire

@@ hdl/jbec_datapath.sv @@
// Datapath: DC prediction, clamping, symbol build, bit packer and output register.
`default_nettype none
module jbec_datapath (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire jbec_pkg::in_item_t  in_item_i,
  input  wire jbec_pkg::jbec_cmd_t cmd_i,
  output jbec_pkg::jbec_status_t   st_o,
  output logic                     out_valid_o,
  input  wire logic                out_ready_i,
  output jbec_pkg::out_item_t      out_item_o
);
  import jbec_pkg::*;

  in_item_t item_q;
  logic signed [11:0] pred_q [3];
  logic [5:0] idx_q, run_q;
  logic [BUF_W-1:0] buf_q, buf_d;
  logic [CNT_W-1:0] cnt_q, cnt_d;
  logic [1:0] zrl_n_q;
  logic [15:0] zrl_code_q;
  logic [4:0] zrl_len_q;
  logic main_q;
  logic [WORD_W-1:0] word_q;
  logic [4:0] word_len_q;
  logic [5:0] rem_q;
  logic out_valid_q;
  out_item_t out_q;

  // evaluation of the captured item
  logic [1:0] comp_sel;
  logic chroma, is_dc, ac_zero, eob, has_main;
  logic signed [11:0] pred_sel, dval, ac_val, val, vm1, magraw;
  logic signed [12:0] diff;
  logic [11:0] absv, mask;
  logic [3:0] nsz;
  logic [7:0] sym;
  logic [ENT_W-1:0] ent, zent;
  logic [WORD_W-1:0] main_word;
  logic [4:0] main_len;
  logic [1:0] zrl_n;
  logic [5:0] rem_calc;

  always_comb begin
    comp_sel = (item_q.component == 2'd3) ? 2'd2 : item_q.component;
    chroma   = comp_sel != 2'd0;
    is_dc    = idx_q == 6'd0;
    pred_sel = pred_q[comp_sel];
    diff     = {item_q.coeff[11], item_q.coeff} - {pred_sel[11], pred_sel};
    if (diff > 13'sd2047)       dval = 12'sd2047;
    else if (diff < -13'sd2047) dval = -12'sd2047;
    else                        dval = diff[11:0];
    if (item_q.coeff > 12'sd1023)       ac_val = 12'sd1023;
    else if (item_q.coeff < -12'sd1023) ac_val = -12'sd1023;
    else                                ac_val = item_q.coeff;
    ac_zero  = ac_val == 12'sd0;
    eob      = !is_dc && ac_zero && (idx_q == LAST_INDEX);
    val      = is_dc ? dval : (eob ? 12'sd0 : ac_val);
    absv     = val[11] ? 12'(-val) : 12'(val);
    nsz      = size_of(absv[10:0]);
    sym      = is_dc ? {4'd0, nsz} : (eob ? EOB_SYM : {run_q[3:0], nsz});
    ent      = code_lookup(!is_dc, chroma, sym);
    zent     = code_lookup(1'b1, chroma, ZRL_SYM);
    vm1      = val - 12'sd1;
    magraw   = val[11] ? vm1 : val;
    mask     = (12'd1 << nsz) - 12'd1;
    main_word = ({11'd0, ent[15:0]} << nsz) | {16'd0, magraw[10:0] & mask[10:0]};
    main_len = ent[20:16] + {1'b0, nsz};
    has_main = is_dc || !ac_zero || eob;
    zrl_n    = (!is_dc && !ac_zero) ? run_q[5:4] : 2'd0;
    rem_calc = 6'({4'd0, zrl_n} * {1'b0, zent[20:16]}) + (has_main ? {1'b0, main_len} : 6'd0);
  end

  // bit packer
  logic [WORD_W-1:0] ld_word;
  logic [4:0] ld_len;
  logic [CNT_W-1:0] shamt;
  logic [7:0] top_byte;

  always_comb begin
    top_byte = buf_q[BUF_W-1 -: 8];
    ld_word  = cmd_i.load_zrl ? {11'd0, zrl_code_q} : word_q;
    ld_len   = cmd_i.load_zrl ? zrl_len_q : word_len_q;
    shamt    = CNT_W'(BUF_W) - cnt_q - {1'b0, ld_len};
    buf_d    = buf_q;
    cnt_d    = cnt_q;
    if (cmd_i.load_zrl || cmd_i.load_main) begin
      buf_d = buf_q | ({7'd0, ld_word} << shamt);
      cnt_d = cnt_q + {1'b0, ld_len};
    end else if (cmd_i.emit_byte) begin
      buf_d = buf_q << 8;
      cnt_d = cnt_q - CNT_W'(8);
    end else if (cmd_i.calc && item_q.action && cnt_q != '0) begin
      // flush: fill the open byte with ones
      buf_d = buf_q | {8'hFF >> cnt_q[2:0], 26'd0};
      cnt_d = CNT_W'(8);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pred_q[0] <= '0;
      pred_q[1] <= '0;
      pred_q[2] <= '0;
      idx_q     <= '0;
      run_q     <= '0;
      buf_q     <= '0;
      cnt_q     <= '0;
      zrl_n_q   <= '0;
      main_q    <= 1'b0;
      rem_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      buf_q <= buf_d;
      cnt_q <= cnt_d;
      if (cmd_i.calc) begin
        if (item_q.action) begin
          pred_q[0] <= '0;
          pred_q[1] <= '0;
          pred_q[2] <= '0;
          idx_q     <= '0;
          run_q     <= '0;
          zrl_n_q   <= '0;
          main_q    <= 1'b0;
          rem_q     <= '0;
        end else begin
          if (is_dc) pred_q[comp_sel] <= pred_sel + dval;
          if (is_dc || !ac_zero || eob) run_q <= '0;
          else                           run_q <= run_q + 6'd1;
          idx_q   <= (idx_q == LAST_INDEX) ? 6'd0 : idx_q + 6'd1;
          zrl_n_q <= zrl_n;
          main_q  <= has_main;
          rem_q   <= rem_calc;
        end
      end
      if (cmd_i.load_zrl) begin
        zrl_n_q <= zrl_n_q - 2'd1;
        rem_q   <= rem_q - {1'b0, zrl_len_q};
      end
      if (cmd_i.load_main) begin
        main_q <= 1'b0;
        rem_q  <= rem_q - {1'b0, word_len_q};
      end
      if (cmd_i.emit_byte || cmd_i.emit_stuff) out_valid_q <= 1'b1;
      else if (out_ready_i)                   out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) item_q <= in_item_i;
    if (cmd_i.calc) begin
      zrl_code_q <= zent[15:0];
      zrl_len_q  <= zent[20:16];
      word_q     <= main_word;
      word_len_q <= main_len;
    end
    if (cmd_i.emit_byte) begin
      out_q.out_byte <= top_byte;
      out_q.last     <= (top_byte != STUFF_TRIGGER) &&
                        (({1'b0, cnt_q} + {1'b0, rem_q}) < 7'd16);
    end else if (cmd_i.emit_stuff) begin
      out_q.out_byte <= 8'h00;
      out_q.last     <= ({1'b0, cnt_q} + {1'b0, rem_q}) < 7'd8;
    end
  end

  always_comb begin
    st_o.cnt_ge8   = cnt_q >= CNT_W'(8);
    st_o.zrl_left  = zrl_n_q != 2'd0;
    st_o.main_left = main_q;
    st_o.out_free  = !out_valid_q || out_ready_i;
    st_o.byte_ff   = top_byte == STUFF_TRIGGER;
  end

  assign out_valid_o = out_valid_q;
  assign out_item_o  = out_q;

endmodule
`default_nettype wire

@@ hdl/jpeg_block_entropy_coder_core.sv @@
// Top level: baseline JPEG block entropy coder (Huffman coding and byte packing).
//
// Input channel (in_valid_i/in_ready_o/in_item_i): one transaction per coefficient in
// zigzag order, or a flush (action = 1) that pads the open byte with ones and clears
// the DC predictors and the block position. Output channel (out_valid_o/out_ready_i/
// out_item_o): one coded byte per transaction, stuffed zero bytes included; last marks
// the final byte produced for an input transaction. Items that complete no byte give
// nothing.
// Sequence: an item is taken in IDLE and evaluated in CALC, then in DRAIN each pending symbol
// (up to three ZRLs and one code plus magnitude) is loaded into the packer and each complete
// byte is emitted when the output register is free, a 0xFF byte followed by its stuffed zero
// from STUFF; DRAIN returns to IDLE once nothing is left. The bit packer has a single
// load/drain path, so loads and byte emissions take turns, a complete byte going first.
// Reset clears the predictors, block position, packer and output valid flag at once.
// A stalled receiver holds the output register; the packer waits and no new item is
// taken until all bytes of the current one are in the output register.
`default_nettype none
module jpeg_block_entropy_coder_core (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire logic                in_valid_i,
  output logic                     in_ready_o,
  input  wire jbec_pkg::in_item_t  in_item_i,
  output logic                     out_valid_o,
  input  wire logic                out_ready_i,
  output jbec_pkg::out_item_t      out_item_o
);
  import jbec_pkg::*;

  jbec_cmd_t    cmd;
  jbec_status_t status;

  // sequencer
  jbec_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .st_i       (status),
    .cmd_o      (cmd)
  );

  // arithmetic, tables and packer
  jbec_datapath u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_item_i   (in_item_i),
    .cmd_i       (cmd),
    .st_o        (status),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_item_o  (out_item_o)
  );

`ifndef NO_ASSERTIONS
  // ready for a new item only with no full byte or pending symbol left in the packer
  a_idle_drained: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_ready_o |-> !status.cnt_ge8 && !status.zrl_left && !status.main_left)
    else $error("new item accepted with bits still pending");

  // a 0xFF byte is never flagged last, since its stuffed zero always follows
  a_ff_not_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_item_o.out_byte == 8'hFF) |-> !out_item_o.last)
    else $error("0xFF byte flagged last");

  // one item at a time
  a_one_item: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && in_ready_o) |=> !in_ready_o)
    else $error("second item accepted back to back");
`endif

endmodule
`default_nettype wire
